[hw/rtl/uart_rx_status_fifo_top_macros.svh]
// Assertion macros shared by the receive status FIFO RTL.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef UART_RX_STATUS_FIFO_TOP_MACROS_SVH
`define UART_RX_STATUS_FIFO_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define URSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define URSF_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define URSF_ASSERT(lbl, prop, msg)
`define URSF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/ursf_pkg.sv]
// Package for the receive status FIFO: sizes, codes, structs and helpers.
// Has no dependencies; the top level, ursf_out_if, ursf_ctrl and ursf_dp use it.
`default_nettype none
package ursf_pkg;
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ST_W   = 5;
    localparam int WORD_W = 8 + ST_W;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    localparam logic [1:0] OP_RECEIVE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERRUN  = 3'd2;
    localparam logic [2:0] ERR_BREAK    = 3'd3;
    localparam logic [2:0] ERR_FRAMING  = 3'd4;
    localparam logic [2:0] ERR_PARITY   = 3'd5;

    localparam int ST_PAR = 0;
    localparam int ST_OVR = 1;
    localparam int ST_FRM = 2;
    localparam int ST_BRK = 3;
    localparam int ST_OVF = 4;

    typedef struct packed {
        logic take;
        logic exec;
        logic rd_issue;
        logic rd_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_hit;
    } t_dp_stat;

    typedef struct packed {
        logic             read_valid;
        logic [7:0]       read_data;
        logic [2:0]       error_code;
        logic             status_parity;
        logic             status_overrun;
        logic             status_framing;
        logic             status_break;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] end_count;
    } t_result;

    function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] nxt;
        nxt = (idx == ADDR_LAST) ? '0 : idx + ADDR_W'(1);
        return nxt;
    endfunction

    function automatic logic [2:0] code_of(input logic [ST_W-1:0] st);
        logic [2:0] code;
        if (st[ST_OVF]) begin
            code = ERR_OVERFLOW;
        end else if (st[ST_OVR]) begin
            code = ERR_OVERRUN;
        end else if (st[ST_BRK]) begin
            code = ERR_BREAK;
        end else if (st[ST_FRM]) begin
            code = ERR_FRAMING;
        end else if (st[ST_PAR]) begin
            code = ERR_PARITY;
        end else begin
            code = ERR_OK;
        end
        return code;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/ursf_in_if.sv]
// Input channel of the receive status FIFO: operation and line flags.
// Uses no package.
`default_nettype none
interface ursf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_data;
    logic       rx_break;
    logic       rx_overrun;
    logic       rx_framing;
    logic       rx_parity;

    modport source (output valid, op, rx_data, rx_break, rx_overrun, rx_framing,
                    rx_parity, input ready);
    modport sink (input valid, op, rx_data, rx_break, rx_overrun, rx_framing,
                  rx_parity, output ready);
endinterface
`default_nettype wire

[hw/rtl/ursf_out_if.sv]
// Result channel of the receive status FIFO.
// Widths of the counts come from ursf_pkg.
`default_nettype none
interface ursf_out_if;
    logic                      valid;
    logic                      ready;
    logic                      read_valid;
    logic [7:0]                read_data;
    logic [2:0]                error_code;
    logic                      status_parity;
    logic                      status_overrun;
    logic                      status_framing;
    logic                      status_break;
    logic [ursf_pkg::CNT_W-1:0] fill_count;
    logic [ursf_pkg::CNT_W-1:0] end_count;

    modport source (output valid, read_valid, read_data, error_code, status_parity,
                    status_overrun, status_framing, status_break, fill_count,
                    end_count, input ready);
    modport sink (input valid, read_valid, read_data, error_code, status_parity,
                  status_overrun, status_framing, status_break, fill_count,
                  end_count, output ready);
endinterface
`default_nettype wire

[hw/rtl/ursf_cfg_if.sv]
// Configuration write channel carrying the end-of-text character.
// Uses no package.
`default_nettype none
interface ursf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/uart_rx_status_fifo_top.sv]
// Top level of the UART receive FIFO with per-byte line status.
// Uses ursf_pkg, the three channel interfaces, ursf_ctrl and ursf_dp.
//
//   Channel   Dir   Carries
//   i_rx      in    op, rx_data, rx_break, rx_overrun, rx_framing, rx_parity
//   o_res     out   read result, error code, query status, fill and end counts
//   i_cfg     in    end-of-text character
//
// An item is taken only when the controller is idle; a read of a held byte passes
// through the extra state ST_RDATA, since the memory read is registered.
// The result is loaded into the output register on leaving ST_EXEC, or ST_RDATA for such a read.
// A pending result sits in the output register; the next item may be taken
// meanwhile but stalls before its own result until that register is free.
// Reset clears indexes, counts and status; the memory is not cleared.
`default_nettype none
`include "uart_rx_status_fifo_top_macros.svh"
module uart_rx_status_fifo_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ursf_in_if.sink   i_rx,
    ursf_out_if.source o_res,
    ursf_cfg_if.sink  i_cfg
);
    ursf_pkg::t_dp_cmd  cmd;
    ursf_pkg::t_dp_stat stat;
    ursf_pkg::t_result  res;
    logic               fill_over;

    assign i_cfg.ready = 1'b1;

    ursf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ursf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_rx.op),
        .i_rx_data    (i_rx.rx_data),
        .i_rx_break   (i_rx.rx_break),
        .i_rx_overrun (i_rx.rx_overrun),
        .i_rx_framing (i_rx.rx_framing),
        .i_rx_parity  (i_rx.rx_parity),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_res        (res)
    );

    assign o_res.read_valid     = res.read_valid;
    assign o_res.read_data      = res.read_data;
    assign o_res.error_code     = res.error_code;
    assign o_res.status_parity  = res.status_parity;
    assign o_res.status_overrun = res.status_overrun;
    assign o_res.status_framing = res.status_framing;
    assign o_res.status_break   = res.status_break;
    assign o_res.fill_count     = res.fill_count;
    assign o_res.end_count      = res.end_count;

    assign fill_over = (o_res.fill_count > ursf_pkg::DEPTH_CNT);

    `URSF_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
    `URSF_ASSERT(a_busy_after_take, i_rx.valid && i_rx.ready |=> !i_rx.ready, "taken while busy")
    `URSF_ASSERT_NEVER(a_fill_bound, o_res.valid && fill_over, "fill count above depth")
endmodule
`default_nettype wire

[hw/rtl/ursf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
`default_nettype none
module ursf_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hw/rtl/ursf_ctrl.sv]
// Controller state machine of the receive status FIFO.
// Uses ursf_pkg for the command and status structs.
`default_nettype none
module ursf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    input  wire ursf_pkg::t_dp_stat i_stat,
    output ursf_pkg::t_dp_cmd       o_cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_RDATA = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              slot_free;
    ursf_pkg::t_dp_cmd cmd;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.take = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.rd_hit) begin
                    cmd.rd_issue = 1'b1;
                    n_state      = ST_RDATA;
                end else if (slot_free) begin
                    cmd.exec = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_RDATA: begin
                if (slot_free) begin
                    cmd.rd_commit = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cmd.exec || cmd.rd_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule
`default_nettype wire

[hw/rtl/ursf_dp.sv]
// Datapath of the receive status FIFO: item register, indexes, counts,
// line status, end character, the byte and status memory and the result register.
// Uses ursf_pkg and instantiates ursf_ram.
`default_nettype none
module ursf_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ursf_pkg::t_dp_cmd   i_cmd,
    output ursf_pkg::t_dp_stat       o_stat,
    input  wire logic [1:0]          i_op,
    input  wire logic [7:0]          i_rx_data,
    input  wire logic                i_rx_break,
    input  wire logic                i_rx_overrun,
    input  wire logic                i_rx_framing,
    input  wire logic                i_rx_parity,
    input  wire logic                i_cfg_valid,
    input  wire logic [7:0]          i_cfg_data,
    output ursf_pkg::t_result        o_res
);
    logic [1:0]                    r_op;
    logic [7:0]                    r_byte;
    logic                          r_brk;
    logic                          r_ovr;
    logic                          r_frm;
    logic                          r_par;
    logic [7:0]                    r_end_char;
    logic [ursf_pkg::ADDR_W-1:0]   r_wr_idx;
    logic [ursf_pkg::ADDR_W-1:0]   n_wr_idx;
    logic [ursf_pkg::ADDR_W-1:0]   r_rd_idx;
    logic [ursf_pkg::ADDR_W-1:0]   n_rd_idx;
    logic [ursf_pkg::CNT_W-1:0]    r_held;
    logic [ursf_pkg::CNT_W-1:0]    n_held;
    logic [ursf_pkg::CNT_W-1:0]    r_marker;
    logic [ursf_pkg::CNT_W-1:0]    n_marker;
    logic [ursf_pkg::ST_W-1:0]     r_last;
    logic [ursf_pkg::ST_W-1:0]     n_last;
    ursf_pkg::t_result             r_res;
    ursf_pkg::t_result             n_res;
    logic                          ram_we;
    logic [ursf_pkg::WORD_W-1:0]   ram_rdata;
    logic [7:0]                    rd_byte;
    logic [ursf_pkg::ST_W-1:0]     rd_status;
    logic [ursf_pkg::ST_W-1:0]     line_status;
    logic [ursf_pkg::CNT_W-1:0]    held_inc;
    logic                          do_store;

    ursf_ram #(
        .P_WIDTH (ursf_pkg::WORD_W),
        .P_DEPTH (ursf_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata ({n_last, r_byte}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_byte     = ram_rdata[7:0];
    assign rd_status   = ram_rdata[ursf_pkg::WORD_W-1:8];
    assign line_status = {1'b0, r_brk, r_frm, r_ovr, r_par};
    assign held_inc    = r_held + ursf_pkg::CNT_W'(1);
    assign do_store    = !(r_brk && r_last[ursf_pkg::ST_BRK])
                         && (r_held < ursf_pkg::DEPTH_CNT);

    assign o_stat.rd_hit = (r_op == ursf_pkg::OP_READ) && (r_held != '0);

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_held   = r_held;
        n_marker = r_marker;
        n_last   = r_last;
        ram_we   = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                ursf_pkg::OP_RECEIVE: begin
                    n_last = line_status;
                    if (do_store) begin
                        n_held = held_inc;
                        if (held_inc == ursf_pkg::DEPTH_CNT) begin
                            n_last[ursf_pkg::ST_OVF] = 1'b1;
                        end
                        ram_we = 1'b1;
                        if (r_byte == r_end_char && r_marker < ursf_pkg::DEPTH_CNT) begin
                            n_marker = r_marker + ursf_pkg::CNT_W'(1);
                        end
                        n_wr_idx = ursf_pkg::next_idx(r_wr_idx);
                    end
                end
                ursf_pkg::OP_CLEAR: begin
                    n_rd_idx = r_wr_idx;
                    n_held   = '0;
                    n_marker = '0;
                    n_last   = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.rd_commit) begin
            n_held   = r_held - ursf_pkg::CNT_W'(1);
            n_rd_idx = ursf_pkg::next_idx(r_rd_idx);
            if (rd_byte == r_end_char && r_marker != '0) begin
                n_marker = r_marker - ursf_pkg::CNT_W'(1);
            end
        end

        n_res = r_res;
        if (i_cmd.exec || i_cmd.rd_commit) begin
            n_res            = '0;
            n_res.fill_count = n_held;
            n_res.end_count  = n_marker;
            if (i_cmd.rd_commit) begin
                n_res.read_valid = 1'b1;
                n_res.read_data  = rd_byte;
                n_res.error_code = ursf_pkg::code_of(rd_status);
            end else if (r_op == ursf_pkg::OP_QUERY) begin
                n_res.status_parity  = r_par | r_last[ursf_pkg::ST_PAR];
                n_res.status_overrun = r_ovr;
                n_res.status_framing = r_frm | r_last[ursf_pkg::ST_FRM];
                n_res.status_break   = r_brk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_op;
            r_byte <= i_rx_data;
            r_brk  <= i_rx_break;
            r_ovr  <= i_rx_overrun;
            r_frm  <= i_rx_framing;
            r_par  <= i_rx_parity;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char <= '0;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_held     <= '0;
            r_marker   <= '0;
            r_last     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_end_char <= i_cfg_data;
            end
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_held   <= n_held;
            r_marker <= n_marker;
            r_last   <= n_last;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire
